// File: sv/shcd_pkg.sv
// Types, register codes and CRC helpers shared by the sync header CRC-16 deframer.
package shcd_pkg;

  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [2:0] {
    PH_SYNC0   = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_HEAD    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD_CRC  = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC_FIRST    = 3'd0,
    REG_SYNC_SECOND   = 3'd1,
    REG_MAX_PAYLOAD   = 3'd2,
    REG_CRC_POLY      = 3'd3,
    REG_CRC_INIT      = 3'd4,
    REG_CRC_REFLECTED = 3'd5
  } cfg_reg_e;

  localparam logic [7:0]  SyncFirstRst   = 8'hA5;
  localparam logic [7:0]  SyncSecondRst  = 8'hA5;
  localparam logic [15:0] MaxPayloadRst  = 16'd1024;
  localparam logic [15:0] CrcPolyRst     = 16'h1021;
  localparam logic [15:0] CrcInitRst     = 16'hFFFF;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] frame_length;
  } res_t;

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

  // One byte through the CRC register, eight shift steps unrolled.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                           input logic [7:0]  b,
                                           input logic [15:0] poly,
                                           input logic        refl);
    logic [15:0] c;
    logic [15:0] p;
    p = refl ? rev16(poly) : poly;
    c = refl ? (crc ^ {8'h00, b}) : (crc ^ {b, 8'h00});
    for (int i = 0; i < 8; i++) begin
      if (refl) begin
        c = c[0] ? ((c >> 1) ^ p) : (c >> 1);
      end else begin
        c = c[15] ? ((c << 1) ^ p) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage

// File: sv/shcd_if.sv
// Valid/ready channel interfaces for the deframer: received bytes, results, register writes.
interface shcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shcd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [15:0] frame_length;

  modport source (output valid, output kind, output data_byte, output frame_type,
                  output frame_flags, output frame_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_type,
                  input frame_flags, input frame_length, output ready);
endinterface

interface shcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: sv/sync_header_crc16_deframer_core.sv
// Sync header CRC-16 deframer: parse state, CRC register and two-entry result buffer.
//
// Takes one received byte per clock. Each byte is parsed and run through the CRC-16 in the
// cycle it is accepted, so the rate is one byte per cycle, set by the byte-wide CRC update.
// A result (payload byte or frame status) goes to the output register, or to the skid
// register while the output register still holds a result; the two let bytes keep flowing
// while one result waits, and rx_i.ready drops only when both hold results. Register writes
// on cfg_i are always taken and act from the next byte; unlisted register indexes are ignored.
module sync_header_crc16_deframer_core
  import shcd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  shcd_rx_if.sink          rx_i,
  shcd_res_if.source       res_o,
  shcd_cfg_if.sink         cfg_i
);

  // Configuration registers
  logic [7:0]  sync_first_q, sync_second_q;
  logic [15:0] max_payload_q, crc_poly_q, crc_init_q;
  logic        crc_refl_q;

  // Parse state
  phase_e      phase_q, phase_d;
  logic [15:0] byte_cnt_q, byte_cnt_d;
  logic [7:0]  hdr_type_q, hdr_type_d;
  logic [7:0]  hdr_flags_q, hdr_flags_d;
  logic [7:0]  len_low_q, len_low_d;
  logic [15:0] pay_len_q, pay_len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_low_q, crc_low_d;

  // Result buffer
  res_t        out_q, out_d, skid_q, skid_d;
  logic        out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  logic        accept, res_vld, pop;
  kind_e       res_kind;
  res_t        res_new;
  logic [7:0]  b;
  logic [15:0] crc_next, cnt_inc;

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = !skid_vld_q;
  assign accept      = rx_i.valid && rx_i.ready;
  assign b           = rx_i.rx_byte;
  assign crc_next    = crc_byte(crc_q, b, crc_poly_q, crc_refl_q);
  assign cnt_inc     = byte_cnt_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstRst;
      sync_second_q <= SyncSecondRst;
      max_payload_q <= MaxPayloadRst;
      crc_poly_q    <= CrcPolyRst;
      crc_init_q    <= CrcInitRst;
      crc_refl_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_SYNC_FIRST:    sync_first_q  <= cfg_i.wdata[7:0];
        REG_SYNC_SECOND:   sync_second_q <= cfg_i.wdata[7:0];
        REG_MAX_PAYLOAD:   max_payload_q <= cfg_i.wdata;
        REG_CRC_POLY:      crc_poly_q    <= cfg_i.wdata;
        REG_CRC_INIT:      crc_init_q    <= cfg_i.wdata;
        REG_CRC_REFLECTED: crc_refl_q    <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = byte_cnt_q;
    hdr_type_d  = hdr_type_q;
    hdr_flags_d = hdr_flags_q;
    len_low_d   = len_low_q;
    pay_len_d   = pay_len_q;
    crc_d       = crc_q;
    crc_low_d   = crc_low_q;
    res_vld     = 1'b0;
    res_kind    = KIND_DATA;
    if (accept) begin
      unique case (phase_q)
        PH_SYNC1: begin
          if (b == sync_second_q) begin
            phase_d    = PH_HEAD;
            byte_cnt_d = '0;
            crc_d      = crc_refl_q ? rev16(crc_init_q) : crc_init_q;
          end else if (b != sync_first_q) begin
            phase_d = PH_SYNC0;
          end
        end
        PH_HEAD: begin
          crc_d      = crc_next;
          byte_cnt_d = cnt_inc;
          if (byte_cnt_q == 16'd0) hdr_type_d = b;
          else if (byte_cnt_q == 16'd1) hdr_flags_d = b;
          else if (byte_cnt_q == 16'd2) len_low_d = b;
          if (cnt_inc >= 16'(HeaderBytes)) begin
            pay_len_d  = {b, len_low_q};
            byte_cnt_d = '0;
            if ({b, len_low_q} > max_payload_q) begin
              phase_d  = PH_SYNC0;
              res_vld  = 1'b1;
              res_kind = KIND_TOO_LONG;
            end else if ({b, len_low_q} == 16'd0) begin
              phase_d = PH_CRC;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_d      = crc_next;
          byte_cnt_d = cnt_inc;
          if (cnt_inc >= pay_len_q) begin
            byte_cnt_d = '0;
            phase_d    = PH_CRC;
          end
          res_vld  = 1'b1;
          res_kind = KIND_DATA;
        end
        PH_CRC: begin
          if (byte_cnt_q == 16'd0) begin
            crc_low_d  = b;
            byte_cnt_d = 16'd1;
          end else begin
            phase_d    = PH_SYNC0;
            byte_cnt_d = '0;
            res_vld    = 1'b1;
            res_kind   = ({b, crc_low_q} == crc_q) ? KIND_GOOD : KIND_BAD_CRC;
          end
        end
        default: begin
          phase_d = (b == sync_first_q) ? PH_SYNC1 : PH_SYNC0;
        end
      endcase
    end
  end

  always_comb begin
    res_new.kind         = res_kind;
    res_new.data_byte    = (res_kind == KIND_DATA) ? b : 8'h00;
    res_new.frame_type   = hdr_type_d;
    res_new.frame_flags  = hdr_flags_d;
    res_new.frame_length = pay_len_d;
  end

  // Two-entry result buffer: output register in front, skid register behind it.
  assign pop = out_vld_q && res_o.ready;

  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else if (res_vld) begin
        out_d     = res_new;
        out_vld_d = 1'b1;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (res_vld) begin
      skid_d     = res_new;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC0;
      byte_cnt_q  <= '0;
      hdr_type_q  <= '0;
      hdr_flags_q <= '0;
      len_low_q   <= '0;
      pay_len_q   <= '0;
      crc_q       <= '0;
      crc_low_q   <= '0;
      out_vld_q   <= 1'b0;
      skid_vld_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      byte_cnt_q  <= byte_cnt_d;
      hdr_type_q  <= hdr_type_d;
      hdr_flags_q <= hdr_flags_d;
      len_low_q   <= len_low_d;
      pay_len_q   <= pay_len_d;
      crc_q       <= crc_d;
      crc_low_q   <= crc_low_d;
      out_vld_q   <= out_vld_d;
      skid_vld_q  <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.kind         = out_q.kind;
  assign res_o.data_byte    = out_q.data_byte;
  assign res_o.frame_type   = out_q.frame_type;
  assign res_o.frame_flags  = out_q.frame_flags;
  assign res_o.frame_length = out_q.frame_length;

endmodule
